[design/rgb_sii_pkg.sv]
// Shared constants, types and helpers for the RGB summed-area (integral image) unit.
// No dependencies.
package rgb_sii_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CFG_W  = 11;
    localparam int CIDX_W = 8;
    localparam int PIX_W  = 24;
    localparam int CHAN_W = 8;
    localparam int BRT_W  = 10;
    localparam int AREA_W = 30;
    // Widest row sum: every pixel of the widest row at full brightness.
    localparam int RSUM_W = $clog2(MAX_WIDTH * 765 + 1);

    typedef logic [CIDX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_FRAME_WIDTH  = t_cfg_index'(0);
    localparam t_cfg_index CFG_FRAME_HEIGHT = t_cfg_index'(1);

    // Last valid position for a size register: zero acts as one, oversize as the max.
    function automatic int last_pos(input logic [CFG_W-1:0] v, input int maxv);
        int r;
        if (v == '0) begin
            r = 0;
        end else if (int'(v) > maxv) begin
            r = maxv - 1;
        end else begin
            r = int'(v) - 1;
        end
        return r;
    endfunction

    function automatic logic [BRT_W-1:0] brightness(input logic [PIX_W-1:0] px);
        return BRT_W'(px[CHAN_W-1:0]) + BRT_W'(px[2*CHAN_W-1:CHAN_W])
             + BRT_W'(px[3*CHAN_W-1:2*CHAN_W]);
    endfunction

endpackage

[design/rgb_sum_integral_image_unit.sv]
// Top level of the RGB summed-area unit: counters, row sum, line store and output register.
// Depends on rgb_sii_pkg.
//
// An accepted item passes through the read stage and then the output register.
// Throughput: one item per clock when not stalled; the single line store port pair
// (one read at accept, one write as the item leaves the read stage) sets that rate.
// Reset (synchronous, active low) clears the counters, the row sum, the pipeline valids
// and restores both size registers to 1024. The line store is not cleared: the first
// row ignores its data, so no clearing pass runs and the block is ready right after reset.
module rgb_sum_integral_image_unit
    import rgb_sii_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  t_cfg_index         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // input items
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [PIX_W-1:0]   i_pixel_rgb,
    input  logic               i_start_of_frame,
    // result items
    output logic               o_valid,
    input  logic               i_ready,
    output logic [AREA_W-1:0]  o_area_sum,
    output logic               o_end_of_row,
    output logic               o_end_of_frame
);

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(1024);
            r_frame_height <= CFG_W'(1024);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // Last column and last row after clamping to the legal range.
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;
    assign w_last = COL_W'(last_pos(r_frame_width, MAX_WIDTH));
    assign h_last = ROW_W'(last_pos(r_frame_height, MAX_HEIGHT));

    // ---------------- accept stage: counters and row sum ----------------
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [RSUM_W-1:0] r_rsum, n_rsum;

    logic [COL_W-1:0]  col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic [BRT_W-1:0]  brt;
    logic              eor, eof;
    logic              in_acc;
    logic              s1_move;

    // Read stage registers.
    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_col;
    logic [RSUM_W-1:0] r_s1_rsum;
    logic              r_s1_row0;
    logic              r_s1_eor;
    logic              r_s1_eof;
    logic              r_s1_fwd;
    logic [AREA_W-1:0] r_s1_fwd_data;
    logic [AREA_W-1:0] s1_above;
    logic [AREA_W-1:0] s1_area;

    // Output register.
    logic              r_out_valid;
    logic [AREA_W-1:0] r_out_area;
    logic              r_out_eor;
    logic              r_out_eof;

    // A start-of-frame mark restarts the item at the origin.
    assign col_cur = i_start_of_frame ? '0 : r_col;
    assign row_cur = i_start_of_frame ? '0 : r_row;
    assign brt     = brightness(i_pixel_rgb);
    // A column at or past the last one ends the row, likewise for rows and the frame.
    assign eor     = (col_cur >= w_last);
    assign eof     = eor && (row_cur >= h_last);

    always_comb begin
        n_rsum = (col_cur == '0) ? RSUM_W'(brt) : r_rsum + RSUM_W'(brt);
        if (eor) begin
            n_col = '0;
            n_row = eof ? '0 : row_cur + ROW_W'(1);
        end else begin
            n_col = col_cur + COL_W'(1);
            n_row = row_cur;
        end
    end

    // Advance the read stage whenever the output register is free or being emptied.
    assign s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_move;
    assign in_acc  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_rsum <= '0;
        end else if (in_acc) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_rsum <= n_rsum;
        end
    end

    // ---------------- line store: previous row's integrals ----------------
    logic [AREA_W-1:0] line_mem [MAX_WIDTH];
    logic [AREA_W-1:0] r_rd_data;

    // Read at accept; hold the read data while the item waits in the read stage.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= line_mem[col_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            line_mem[r_s1_col] <= s1_area;
        end
    end

    // ---------------- read stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // When the leaving item writes the entry being read this cycle (one-pixel rows),
    // capture its value and bypass the stale read data.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_col      <= col_cur;
            r_s1_rsum     <= n_rsum;
            r_s1_row0     <= (row_cur == '0);
            r_s1_eor      <= eor;
            r_s1_eof      <= eof;
            r_s1_fwd      <= r_s1_valid && (r_s1_col == col_cur);
            r_s1_fwd_data <= s1_area;
        end
    end

    // The first row takes zero in place of the line store.
    assign s1_above = r_s1_row0 ? '0 : (r_s1_fwd ? r_s1_fwd_data : r_rd_data);
    assign s1_area  = s1_above + AREA_W'(r_s1_rsum);

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_area <= s1_area;
            r_out_eor  <= r_s1_eor;
            r_out_eof  <= r_s1_eof;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_area_sum     = r_out_area;
    assign o_end_of_row   = r_out_eor;
    assign o_end_of_frame = r_out_eof;

    // ---------------- assertions ----------------
    a_eof_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_end_of_frame || o_end_of_row))
        else $error("end of frame without end of row");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted item lost before read stage");

    a_fwd_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_s1_valid && (r_s1_col == col_cur)) |=> r_s1_fwd)
        else $error("missing bypass on back-to-back access to one entry");

    a_row0_no_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_row0) |-> (s1_area == AREA_W'(r_s1_rsum)))
        else $error("first row used line store data");

    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1_col)))
        else $error("read stage changed while stalled");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for rgb_sum_integral_image_unit: feeds raster-order pixels, predicts every
// summed-area result in a scoreboard class and compares it field by field. Depends on rgb_sii_pkg.
module tb_top;
    import rgb_sii_pkg::*;

    localparam int         CLK_PERIOD     = 8;
    localparam int         RESET_CYCLES   = 7;
    localparam int         RANDOM_PIXELS  = 500;
    localparam int         QUIET_TAIL     = 100;
    localparam int         REPORT_LIMIT   = 10;
    localparam longint     RUN_LIMIT_NS   = 4_000_000;
    // Indexes past the two size registers; writes there must change nothing.
    localparam t_cfg_index CFG_SPARE_LOW  = t_cfg_index'(2);
    localparam t_cfg_index CFG_SPARE_HIGH = '1;
    localparam logic [PIX_W-1:0] PIX_WHITE = '1;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic              row_end;
        logic              frame_end;
    } t_area_result;

    // Integral-image predictor plus the queue of results still owed by the block.
    class area_scoreboard;
        logic [AREA_W-1:0] line_mem [MAX_WIDTH];
        int unsigned       row_acc;
        int unsigned       col_pos;
        int unsigned       row_pos;
        logic [CFG_W-1:0]  width_reg;
        logic [CFG_W-1:0]  height_reg;
        t_area_result      pending[$];
        int unsigned       fail_count;
        int unsigned       checked;
        int unsigned       frames;

        function new();
            width_reg  = CFG_W'(MAX_WIDTH);
            height_reg = CFG_W'(MAX_HEIGHT);
            row_acc    = 0;
            col_pos    = 0;
            row_pos    = 0;
            fail_count = 0;
            checked    = 0;
            frames     = 0;
        endfunction

        // Zero behaves as one, anything above the maximum as the maximum.
        function int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned maxv);
            if (v == '0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function void write_reg(t_cfg_index idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg = val;
                CFG_FRAME_HEIGHT: height_reg = val;
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px, logic sof);
            int unsigned       w;
            int unsigned       h;
            int unsigned       lum;
            int unsigned       c;
            logic [AREA_W-1:0] above;
            t_area_result      r;
            w   = eff_size(width_reg, MAX_WIDTH);
            h   = eff_size(height_reg, MAX_HEIGHT);
            lum = int'(px[7:0]) + int'(px[15:8]) + int'(px[23:16]);
            if (sof) begin
                col_pos = 0;
                row_pos = 0;
            end
            c       = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
            row_acc = (c == 0) ? lum : row_acc + lum;
            above   = (row_pos == 0) ? '0 : line_mem[c];
            r.area  = AREA_W'(above + row_acc);
            line_mem[c] = r.area;
            r.row_end   = (c >= w - 1);
            r.frame_end = r.row_end && (row_pos >= h - 1);
            if (r.row_end) begin
                col_pos = 0;
                row_pos = r.frame_end ? 0 : row_pos + 1;
            end else begin
                col_pos = c + 1;
            end
            if (r.frame_end) frames++;
            pending.push_back(r);
        endfunction

        function void report(string what, t_area_result want, t_area_result got);
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("[%0t] %s: expected area=%0d eor=%0b eof=%0b, got area=%0d eor=%0b eof=%0b",
                         $time, what, want.area, want.row_end, want.frame_end,
                         got.area, got.row_end, got.frame_end);
            end
        endfunction

        function void check_result(logic [AREA_W-1:0] area, logic row_end, logic frame_end);
            t_area_result got;
            t_area_result want;
            got = '{area, row_end, frame_end};
            if (pending.size() == 0) begin
                report("result with nothing outstanding", '0, got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.area !== want.area || got.row_end !== want.row_end ||
                got.frame_end !== want.frame_end) begin
                report("mismatch", want, got);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_index         i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic [PIX_W-1:0]   i_pixel_rgb;
    logic               i_start_of_frame;
    logic               o_valid;
    logic               i_ready;
    logic [AREA_W-1:0]  o_area_sum;
    logic               o_end_of_row;
    logic               o_end_of_frame;

    area_scoreboard sb = new();

    // Quiet mode turns off idling on both sides for the tail of the run.
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int unsigned pixels_sent = 0;
    int unsigned cfg_writes = 0;

    rgb_sum_integral_image_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pixel_rgb      (i_pixel_rgb),
        .i_start_of_frame (i_start_of_frame),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_area_sum       (o_area_sum),
        .o_end_of_row     (o_end_of_row),
        .o_end_of_frame   (o_end_of_frame)
    );

    always begin
        i_clk = 1'b0;
        #(CLK_PERIOD / 2);
        i_clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    // Result side: hold ready low in random bursts, otherwise take every item.
    always @(negedge i_clk) begin
        if (!quiet && stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 10) begin
            stall_left <= $urandom_range(0, 11);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Check each result item on the edge that moves it; values read here are pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_area_sum, o_end_of_row, o_end_of_frame);
        end
    end

    // Present one pixel, maybe after an idle burst, and hold it until the block takes it.
    // Called and returning at a falling edge, so valid is never lowered and raised in one step.
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic sof);
        if (!quiet && $urandom_range(0, 99) < 12) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_pixel_rgb      <= px;
        i_start_of_frame <= sof;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(px, sof);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // One register write; leaves the write valid high, the caller drops it.
    task automatic write_cfg(input t_cfg_index idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        cfg_writes++;
        @(negedge i_clk);
    endtask

    // Write both sizes in random order; optionally poke the unused indexes afterwards.
    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input bit spare);
        if ($urandom_range(0, 1) != 0) begin
            write_cfg(CFG_FRAME_WIDTH, w);
            write_cfg(CFG_FRAME_HEIGHT, h);
        end else begin
            write_cfg(CFG_FRAME_HEIGHT, h);
            write_cfg(CFG_FRAME_WIDTH, w);
        end
        if (spare) begin
            write_cfg(CFG_SPARE_LOW, CFG_W'($urandom()));
            write_cfg(CFG_SPARE_HIGH, '1);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid and hold until every owed result is back, plus a short settle for latency.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] random_pixel();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) return PIX_WHITE;
        if (pick == 2) return '0;
        return PIX_W'($urandom());
    endfunction

    initial begin
        int unsigned      random_sent;
        int unsigned      len;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic             sof;
        logic             force_sof;
        random_sent      = 0;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_FRAME_WIDTH;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_pixel_rgb      = '0;
        i_start_of_frame = 1'b0;
        i_ready          = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: 3x2 frames. Walk each channel alone, all-ones and all-zeros pixels,
        // then a frame with no start mark right after end of frame, then a restart mid-row.
        configure(CFG_W'(3), CFG_W'(2), 1'b1);
        send_pixel(PIX_WHITE, 1'b1);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h0000FF, 1'b0);
        send_pixel(24'h00FF00, 1'b0);
        send_pixel(24'hFF0000, 1'b0);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(24'h123456, 1'b0);
        send_pixel(24'hFEDCBA, 1'b0);
        send_pixel(24'hA5A5A5, 1'b1);
        send_pixel(24'h5A5A5A, 1'b0);
        send_pixel(24'h010203, 1'b0);
        send_pixel(PIX_WHITE, 1'b0);
        send_pixel(24'h808080, 1'b0);
        send_pixel(24'h7F7F7F, 1'b0);

        // Zero sizes act as one: every pixel closes its row and its frame.
        wait_idle();
        configure('0, '0, 1'b0);
        repeat (3) send_pixel(random_pixel(), 1'b0);

        // Shrink the width mid-row: a column already past the new last column ends the row.
        wait_idle();
        configure(CFG_W'(6), CFG_W'(4), 1'b0);
        send_pixel(random_pixel(), 1'b1);
        repeat (3) send_pixel(random_pixel(), 1'b0);
        wait_idle();
        configure(CFG_W'(2), CFG_W'(4), 1'b0);
        repeat (3) send_pixel(random_pixel(), 1'b0);

        // Oversize registers clamp to the maximum: the start of a maximum-width row
        // of full-brightness pixels must not close the row.
        wait_idle();
        configure('1, CFG_W'(MAX_HEIGHT + 1), 1'b0);
        send_pixel(PIX_WHITE, 1'b1);
        repeat (15) send_pixel(PIX_WHITE, 1'b0);

        // Random phases: mostly small frames opened by a start mark with random content;
        // some phases continue the current frame under new sizes, a few stray start marks.
        while (random_sent < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0:       w = '0;
                1:       w = CFG_W'($urandom_range(MAX_WIDTH + 1, 2047));
                2, 3:    w = CFG_W'($urandom_range(13, 64));
                default: w = CFG_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       h = '0;
                1:       h = CFG_W'($urandom_range(MAX_HEIGHT + 1, 2047));
                2:       h = CFG_W'($urandom_range(6, 40));
                default: h = CFG_W'($urandom_range(1, 5));
            endcase
            // A wider row within a frame would read line store entries the row above
            // never wrote; open a new frame whenever the width grows.
            force_sof = sb.eff_size(w, MAX_WIDTH) > sb.eff_size(sb.width_reg, MAX_WIDTH);
            wait_idle();
            configure(w, h, $urandom_range(0, 7) == 0);
            len = $urandom_range(20, 80);
            for (int unsigned k = 0; k < len && random_sent < RANDOM_PIXELS; k++) begin
                quiet = (random_sent >= RANDOM_PIXELS - QUIET_TAIL);
                sof   = (k == 0) ? (force_sof || $urandom_range(0, 3) != 0)
                                 : ($urandom_range(0, 49) == 0);
                send_pixel(random_pixel(), sof);
                random_sent++;
            end
        end

        // Drain, let the pipeline settle, then report.
        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d pixels, %0d completed frames, %0d register writes; %0d results checked, %0d failures.",
                 pixels_sent, sb.frames, cfg_writes, sb.checked, sb.fail_count);
        if (sb.fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results outstanding", sb.pending.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

[rgb_sum_integral_image_unit.f]
design/rgb_sii_pkg.sv
design/rgb_sum_integral_image_unit.sv
tb/tb_top.sv
